// File: rtl/core/http_request_span_parser_top_macros.svh
// Assertion macros shared by the span parser checker.
`ifndef HTTP_REQUEST_SPAN_PARSER_TOP_MACROS_SVH
`define HTTP_REQUEST_SPAN_PARSER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define HRSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("span parser check failed");

// Next-cycle implication, clocked on clk and held off during reset.
`define HRSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("span parser check failed");

`endif

// File: rtl/core/hrsp_pkg.sv
// Package with types, codes and method tables for the HTTP request span parser.
package hrsp_pkg;

  localparam int HRSP_MAX_HEADERS = 16;
  localparam int HRSP_OFFSET_BITS = 16;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 3;

  localparam logic [2:0] KIND_METHOD = 3'd0;
  localparam logic [2:0] KIND_URL    = 3'd1;
  localparam logic [2:0] KIND_KEY    = 3'd2;
  localparam logic [2:0] KIND_VALUE  = 3'd3;
  localparam logic [2:0] KIND_BODY   = 3'd4;

  localparam logic [2:0] MC_NONE = 3'd0;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [9:0] {
    PH_METHOD       = 10'b00_0000_0001,
    PH_AFTER_METHOD = 10'b00_0000_0010,
    PH_URL          = 10'b00_0000_0100,
    PH_SKIP_LINE    = 10'b00_0000_1000,
    PH_LINE_START   = 10'b00_0001_0000,
    PH_KEY          = 10'b00_0010_0000,
    PH_SPACES       = 10'b00_0100_0000,
    PH_VALUE        = 10'b00_1000_0000,
    PH_SKIP_NL      = 10'b01_0000_0000,
    PH_BODY         = 10'b10_0000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  code;
    logic [15:0] start;
    logic [15:0] length;
    logic [3:0]  slot;
    logic        last;
  } result_t;

  // Candidate order: GET, POST, PUT, DELETE.
  function automatic logic [7:0] method_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [7:0] ch;
    ch = CH_NUL;
    case (idx)
      2'd0: begin
        case (pos)
          3'd0: ch = "G";
          3'd1: ch = "E";
          3'd2: ch = "T";
          default: ch = CH_NUL;
        endcase
      end
      2'd1: begin
        case (pos)
          3'd0: ch = "P";
          3'd1: ch = "O";
          3'd2: ch = "S";
          3'd3: ch = "T";
          default: ch = CH_NUL;
        endcase
      end
      2'd2: begin
        case (pos)
          3'd0: ch = "P";
          3'd1: ch = "U";
          3'd2: ch = "T";
          default: ch = CH_NUL;
        endcase
      end
      default: begin
        case (pos)
          3'd0: ch = "D";
          3'd1: ch = "E";
          3'd2: ch = "L";
          3'd3: ch = "E";
          3'd4: ch = "T";
          3'd5: ch = "E";
          default: ch = CH_NUL;
        endcase
      end
    endcase
    return ch;
  endfunction

  function automatic logic [3:0] method_len(input logic [1:0] idx);
    logic [3:0] len;
    case (idx)
      2'd0: len = 4'd3;
      2'd1: len = 4'd4;
      2'd2: len = 4'd3;
      default: len = 4'd6;
    endcase
    return len;
  endfunction

  function automatic logic is_ws(input logic [7:0] b);
    return b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
  endfunction

endpackage

// File: rtl/core/http_request_span_parser_top.sv
// Top level of the HTTP request span parser: byte decoder and result queue.
//
//   Channel  Dir  Handshake              Payload
//   in_      in   in_tvalid/in_tready    tdata request byte, tlast final byte
//   out_     out  out_tvalid/out_tready  tdata span fields, tuser kind, tlast last result
//
// One byte is decided per clock cycle while the input is ready; its zero to three
// results go into a four-word output queue in the same edge and leave one word
// per cycle while out_tready is high. The input is ready while the queue holds
// at most one word, so the output drain rate sets the pace when bytes cause results.
// Reset (rst_n low, synchronous) empties the queue and starts a new request.
module http_request_span_parser_top #(
  parameter int MAX_HEADERS = hrsp_pkg::HRSP_MAX_HEADERS,
  parameter int OFFSET_BITS = hrsp_pkg::HRSP_OFFSET_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hrsp_pkg::IN_DATA_W-1:0]  in_tdata,   // [7:0] data_byte
  input  logic                          in_tlast,   // final_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [2:0] method_code, [18:3] span_start, [34:19] span_length,
  // [38:35] header_slot, [39] zero
  output logic [hrsp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [hrsp_pkg::OUT_USER_W-1:0] out_tuser,  // [2:0] span_kind
  output logic                          out_tlast   // last_result
);
  import hrsp_pkg::*;

  localparam int HSW = $clog2(MAX_HEADERS + 1);
  localparam int WB  = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
  localparam int QD  = 4;

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             cand_r, cand_nxt;
  logic [2:0]             mpos_r, mpos_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt;
  logic [OFFSET_BITS-1:0] start_r, start_nxt;
  logic [HSW-1:0]         hs_r, hs_nxt;
  result_t                q_r [QD];
  result_t                q_nxt [QD];
  logic [2:0]             cnt_r, cnt_nxt;

  result_t                res [3];
  logic [1:0]             n_new;
  logic                   accept;
  logic                   pop;

  function automatic logic [15:0] sat16(input logic [OFFSET_BITS-1:0] v);
    logic [WB-1:0] w;
    w = WB'(v);
    return (w > WB'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic result_t mk_res(input logic [2:0] kind, input logic [2:0] code,
                                     input logic [OFFSET_BITS-1:0] s,
                                     input logic [OFFSET_BITS-1:0] e,
                                     input logic [3:0] slot);
    result_t r;
    r.kind   = kind;
    r.code   = code;
    r.start  = sat16(s);
    r.length = sat16((e >= s) ? (e - s) : '0);
    r.slot   = slot;
    r.last   = 1'b0;
    return r;
  endfunction

  assign accept     = in_tvalid && in_tready;
  assign in_tready  = (cnt_r <= 3'd1);
  assign out_tvalid = (cnt_r != 3'd0);
  assign pop        = out_tvalid && out_tready;
  assign out_tuser  = q_r[0].kind;
  assign out_tdata  = {1'b0, q_r[0].slot, q_r[0].length, q_r[0].start, q_r[0].code};
  assign out_tlast  = q_r[0].last;

  always_comb begin
    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] pos;
    logic [OFFSET_BITS-1:0] nxt;
    logic [OFFSET_BITS-1:0] body_start;
    logic [3:0]             live;
    logic                   fnd;
    logic [1:0]             found;
    logic                   redo;
    logic [1:0]             n;
    phase_t                 ph;
    logic [3:0]             cand;
    logic [2:0]             mpos;
    logic [OFFSET_BITS-1:0] st;
    logic [HSW-1:0]         hs;

    b     = in_tdata;
    pos   = off_r;
    nxt   = (off_r != '1) ? (off_r + 1'b1) : off_r;
    ph    = phase_r;
    cand  = cand_r;
    mpos  = mpos_r;
    st    = start_r;
    hs    = hs_r;
    n     = 2'd0;
    redo  = 1'b1;
    live  = 4'd0;
    fnd   = 1'b0;
    found = 2'd0;
    body_start = nxt;
    for (int j = 0; j < 3; j++) begin
      res[j] = mk_res(KIND_METHOD, MC_NONE, '0, '0, 4'd0);
    end

    for (int it = 0; it < 3; it++) begin
      if (redo) begin
        redo = 1'b0;
        case (ph)
          PH_METHOD: begin
            live = 4'd0;
            fnd  = 1'b0;
            for (int i = 0; i < 4; i++) begin
              if (cand[i] && ({1'b0, mpos} < method_len(2'(i))) &&
                  (method_char(2'(i), mpos) == b)) begin
                live[i] = 1'b1;
                if (method_len(2'(i)) == ({1'b0, mpos} + 4'd1)) begin
                  fnd   = 1'b1;
                  found = 2'(i);
                end
              end
            end
            cand = live;
            if (fnd) begin
              res[n] = mk_res(KIND_METHOD, {1'b0, found} + 3'd1, '0,
                              OFFSET_BITS'(mpos) + 1'b1, 4'd0);
              n  = n + 2'd1;
              ph = PH_AFTER_METHOD;
            end else if (live == 4'd0) begin
              res[n] = mk_res(KIND_METHOD, MC_NONE, '0, '0, 4'd0);
              n    = n + 2'd1;
              ph   = (mpos == 3'd0) ? PH_AFTER_METHOD : PH_SKIP_LINE;
              redo = 1'b1;
            end else begin
              mpos = mpos + 3'd1;
            end
          end
          PH_AFTER_METHOD: begin
            if (b == CH_SPACE) begin
              st = nxt;
              ph = PH_URL;
            end else begin
              ph   = PH_SKIP_LINE;
              redo = 1'b1;
            end
          end
          PH_URL: begin
            if (is_ws(b)) begin
              res[n] = mk_res(KIND_URL, MC_NONE, st, pos, 4'd0);
              n    = n + 2'd1;
              ph   = PH_SKIP_LINE;
              redo = 1'b1;
            end
          end
          PH_SKIP_LINE: begin
            if (b == CH_LF) begin
              ph = PH_LINE_START;
            end
          end
          PH_LINE_START: begin
            if ((hs >= HSW'(MAX_HEADERS)) || (b == CH_NUL) || (b == CH_LF)) begin
              ph = PH_SKIP_NL;
            end else begin
              st = pos;
              ph = PH_KEY;
            end
            redo = 1'b1;
          end
          PH_KEY: begin
            if (b == CH_COLON) begin
              res[n] = mk_res(KIND_KEY, MC_NONE, st, pos, 4'(hs));
              n  = n + 2'd1;
              ph = PH_SPACES;
            end
          end
          PH_SPACES: begin
            if (b != CH_SPACE) begin
              st   = pos;
              ph   = PH_VALUE;
              redo = 1'b1;
            end
          end
          PH_VALUE: begin
            if (b == CH_LF) begin
              res[n] = mk_res(KIND_VALUE, MC_NONE, st, pos, 4'(hs));
              n  = n + 2'd1;
              hs = hs + 1'b1;
              ph = PH_LINE_START;
            end
          end
          PH_SKIP_NL: begin
            if (b != CH_LF) begin
              st = pos;
              ph = PH_BODY;
            end
          end
          default: begin
            ph = PH_BODY;
          end
        endcase
      end
    end

    if (in_tlast) begin
      case (ph)
        PH_METHOD: begin
          res[n] = mk_res(KIND_METHOD, MC_NONE, '0, '0, 4'd0);
          n = n + 2'd1;
        end
        PH_URL: begin
          res[n] = mk_res(KIND_URL, MC_NONE, st, nxt, 4'd0);
          n = n + 2'd1;
        end
        PH_KEY: begin
          res[n] = mk_res(KIND_KEY, MC_NONE, st, nxt, 4'(hs));
          n = n + 2'd1;
          res[n] = mk_res(KIND_VALUE, MC_NONE, nxt, nxt, 4'(hs));
          n = n + 2'd1;
        end
        PH_SPACES: begin
          res[n] = mk_res(KIND_VALUE, MC_NONE, nxt, nxt, 4'(hs));
          n = n + 2'd1;
        end
        PH_VALUE: begin
          res[n] = mk_res(KIND_VALUE, MC_NONE, st, nxt, 4'(hs));
          n = n + 2'd1;
        end
        PH_BODY: begin
          body_start = st;
        end
        default: begin
          body_start = nxt;
        end
      endcase
      res[n] = mk_res(KIND_BODY, MC_NONE, body_start, nxt, 4'd0);
      n = n + 2'd1;
    end

    for (int j = 0; j < 3; j++) begin
      res[j].last = ((2'(j) + 2'd1) == n);
    end

    n_new = accept ? n : 2'd0;

    if (!accept) begin
      phase_nxt = phase_r;
      cand_nxt  = cand_r;
      mpos_nxt  = mpos_r;
      off_nxt   = off_r;
      start_nxt = start_r;
      hs_nxt    = hs_r;
    end else if (in_tlast) begin
      phase_nxt = PH_METHOD;
      cand_nxt  = 4'hF;
      mpos_nxt  = 3'd0;
      off_nxt   = '0;
      start_nxt = '0;
      hs_nxt    = '0;
    end else begin
      phase_nxt = ph;
      cand_nxt  = cand;
      mpos_nxt  = mpos;
      off_nxt   = nxt;
      start_nxt = st;
      hs_nxt    = hs;
    end
  end

  always_comb begin
    result_t    sh [QD];
    logic [2:0] base;

    for (int i = 0; i < QD; i++) begin
      sh[i] = (pop && (i < QD - 1)) ? q_r[(i + 1) % QD] : q_r[i];
    end
    base = cnt_r - {2'd0, pop};
    for (int i = 0; i < QD; i++) begin
      q_nxt[i] = sh[i];
      for (int j = 0; j < 3; j++) begin
        if ((2'(j) < n_new) && ((base + 3'(j)) == 3'(i))) begin
          q_nxt[i] = res[j];
        end
      end
    end
    cnt_nxt = base + {1'b0, n_new};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      cand_r  <= 4'hF;
      mpos_r  <= 3'd0;
      off_r   <= '0;
      start_r <= '0;
      hs_r    <= '0;
      cnt_r   <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
      cand_r  <= cand_nxt;
      mpos_r  <= mpos_nxt;
      off_r   <= off_nxt;
      start_r <= start_nxt;
      hs_r    <= hs_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QD; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

// File: rtl/core/hrsp_checker.sv
// Port-level checker for the HTTP request span parser, bound to the top level.
`include "http_request_span_parser_top_macros.svh"

module hrsp_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [hrsp_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [hrsp_pkg::OUT_USER_W-1:0] out_tuser,
  input logic                            out_tlast
);
  import hrsp_pkg::*;

  // A stalled word keeps its contents.
  `HRSP_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  `HRSP_ASSERT_NOW(a_kind_range, out_tvalid, out_tuser <= KIND_BODY)

  // The body span closes every request and so always ends the results of its byte.
  `HRSP_ASSERT_NOW(a_body_last, out_tvalid && (out_tuser == KIND_BODY), out_tlast)

  // Only key and value spans carry a header slot; only method spans carry a code.
  `HRSP_ASSERT_NOW(a_slot_zero, out_tvalid && (out_tuser != KIND_KEY) && (out_tuser != KIND_VALUE), out_tdata[38:35] == 4'd0)

  `HRSP_ASSERT_NOW(a_code_zero, out_tvalid && (out_tuser != KIND_METHOD), out_tdata[2:0] == MC_NONE)

endmodule

bind http_request_span_parser_top hrsp_checker u_hrsp_checker (.*);

// File: test/http_request_span_parser_top_tb.sv
// Self-checking testbench that streams request bytes into the span parser and checks each span word.
module http_request_span_parser_top_tb;
  import hrsp_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int N_ROWS = 20;
  localparam int RANDOM_BYTES = 30;
  localparam logic [15:0] OFFSET_TOP = 16'hFFFF;

  localparam logic [2:0] MC_GET    = 3'd1;
  localparam logic [2:0] MC_POST   = 3'd2;
  localparam logic [2:0] MC_PUT    = 3'd3;
  localparam logic [2:0] MC_DELETE = 3'd4;

  localparam logic [7:0] VERB_TXT [4][6] = '{
    '{"G", "E", "T", CH_NUL, CH_NUL, CH_NUL},
    '{"P", "O", "S", "T", CH_NUL, CH_NUL},
    '{"P", "U", "T", CH_NUL, CH_NUL, CH_NUL},
    '{"D", "E", "L", "E", "T", "E"}
  };
  localparam int VERB_LEN [4] = '{3, 4, 3, 6};
  localparam logic [2:0] VERB_CODE [4] = '{MC_GET, MC_POST, MC_PUT, MC_DELETE};

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       known;
    logic [4:0] row;
  } req_byte_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;

  phase_t      phase;
  logic [3:0]  cands;
  logic [2:0]  mpos;
  logic [15:0] offs;
  logic [15:0] span_from;
  logic [4:0]  hdr_cnt;

  result_t    span_buf [$];
  result_t    span_q [$];
  req_byte_t  stim_q [$];
  req_byte_t  on_bus;
  logic [7:0] req_txt [$];

  string   row_txt [N_ROWS];
  int      row_nul [N_ROWS];
  int      row_known [N_ROWS];
  result_t row_word [N_ROWS][3];

  int n_stim = 0;
  int n_accepted = 0;
  int n_words = 0;
  int n_err = 0;
  int n_requests = 0;
  int n_directed = 0;
  int cycle_cnt = 0;
  int calm_lo = 0;
  int calm_hi = 0;

  http_request_span_parser_top uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .out_tlast(out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic int clip16(input int v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic result_t span_word(input logic [2:0] kind, input logic [2:0] code,
                                        input int from, input int len, input int slot,
                                        input bit is_last);
    result_t w;
    w.kind = kind;
    w.code = code;
    w.start = 16'(from);
    w.length = 16'(len);
    w.slot = 4'(slot);
    w.last = is_last;
    return w;
  endfunction

  function automatic logic [7:0] pick_char(input bit no_ws, input bit no_colon,
                                           input bit no_eol);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                        8'($urandom_range(33, 126));
    end while ((no_ws && (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR})) ||
               (no_colon && c == CH_COLON) || (no_eol && (c == CH_LF || c == CH_NUL)));
    return c;
  endfunction

  task automatic note_diff(input string field, input logic [39:0] got,
                           input logic [39:0] want);
    n_err++;
    $display("word %0d: %s is 0x%0h, expected 0x%0h", n_words, field, got, want);
  endtask

  task automatic reset_parser();
    phase = PH_METHOD;
    cands = 4'hF;
    mpos = '0;
    offs = '0;
    span_from = '0;
    hdr_cnt = '0;
  endtask

  task automatic add_span(input logic [2:0] kind, input logic [2:0] code, input int from,
                          input int upto, input int slot);
    span_buf.push_back(span_word(kind, code, clip16(from),
                                 clip16((upto >= from) ? upto - from : 0), slot, 1'b0));
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    int pos, nxt, body_from, m, k, found;
    logic [3:0] live;
    bit again;
    result_t w;
    pos = int'(offs);
    nxt = (offs < OFFSET_TOP) ? int'(offs) + 1 : int'(offs);
    span_buf.delete();
    do begin
      again = 1'b0;
      case (phase)
        PH_METHOD: begin
          live = '0;
          found = -1;
          m = int'(mpos);
          for (k = 0; k < 4; k++) begin
            if (cands[k] && m < VERB_LEN[k] && VERB_TXT[k][m] == b) begin
              live[k] = 1'b1;
              if (VERB_LEN[k] == m + 1) found = k;
            end
          end
          cands = live;
          if (found >= 0) begin
            add_span(KIND_METHOD, VERB_CODE[found], 0, m + 1, 0);
            phase = PH_AFTER_METHOD;
          end else if (live == '0) begin
            add_span(KIND_METHOD, MC_NONE, 0, 0, 0);
            phase = (m == 0) ? PH_AFTER_METHOD : PH_SKIP_LINE;
            again = 1'b1;
          end else begin
            mpos = 3'(m + 1);
          end
        end
        PH_AFTER_METHOD: begin
          if (b == CH_SPACE) begin
            span_from = 16'(nxt);
            phase = PH_URL;
          end else begin
            phase = PH_SKIP_LINE;
            again = 1'b1;
          end
        end
        PH_URL: begin
          if (b inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
            add_span(KIND_URL, MC_NONE, int'(span_from), pos, 0);
            phase = PH_SKIP_LINE;
            again = 1'b1;
          end
        end
        PH_SKIP_LINE: begin
          if (b == CH_LF) phase = PH_LINE_START;
        end
        PH_LINE_START: begin
          if (hdr_cnt >= HRSP_MAX_HEADERS || b == CH_NUL || b == CH_LF) begin
            phase = PH_SKIP_NL;
          end else begin
            span_from = 16'(pos);
            phase = PH_KEY;
          end
          again = 1'b1;
        end
        PH_KEY: begin
          if (b == CH_COLON) begin
            add_span(KIND_KEY, MC_NONE, int'(span_from), pos, int'(hdr_cnt));
            phase = PH_SPACES;
          end
        end
        PH_SPACES: begin
          if (b != CH_SPACE) begin
            span_from = 16'(pos);
            phase = PH_VALUE;
            again = 1'b1;
          end
        end
        PH_VALUE: begin
          if (b == CH_LF) begin
            add_span(KIND_VALUE, MC_NONE, int'(span_from), pos, int'(hdr_cnt));
            hdr_cnt = hdr_cnt + 5'd1;
            phase = PH_LINE_START;
          end
        end
        PH_SKIP_NL: begin
          if (b != CH_LF) begin
            span_from = 16'(pos);
            phase = PH_BODY;
          end
        end
        default: phase = PH_BODY;
      endcase
    end while (again);
    offs = 16'(nxt);
    if (fin) begin
      body_from = nxt;
      case (phase)
        PH_METHOD: add_span(KIND_METHOD, MC_NONE, 0, 0, 0);
        PH_URL: add_span(KIND_URL, MC_NONE, int'(span_from), nxt, 0);
        PH_KEY: begin
          add_span(KIND_KEY, MC_NONE, int'(span_from), nxt, int'(hdr_cnt));
          add_span(KIND_VALUE, MC_NONE, nxt, nxt, int'(hdr_cnt));
        end
        PH_SPACES: add_span(KIND_VALUE, MC_NONE, nxt, nxt, int'(hdr_cnt));
        PH_VALUE: add_span(KIND_VALUE, MC_NONE, int'(span_from), nxt, int'(hdr_cnt));
        PH_BODY: body_from = int'(span_from);
        default: ;
      endcase
      add_span(KIND_BODY, MC_NONE, body_from, nxt, 0);
      reset_parser();
    end
    if (span_buf.size() > 0) begin
      w = span_buf.pop_back();
      w.last = 1'b1;
      span_buf.push_back(w);
    end
  endtask

  task automatic push_text(input string s);
    int k;
    for (k = 0; k < s.len(); k++) req_txt.push_back(s[k]);
  endtask

  task automatic add_request(input int known_row);
    req_byte_t it;
    int k;
    for (k = 0; k < req_txt.size(); k++) begin
      it.data = req_txt[k];
      it.fin = (k == req_txt.size() - 1);
      it.known = it.fin && known_row >= 0;
      it.row = (known_row >= 0) ? 5'(known_row) : '0;
      stim_q.push_back(it);
    end
    n_requests++;
  endtask

  task automatic build_random_request();
    int k, n, v, h, m, cut;
    req_txt.delete();
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 10);
      for (k = 0; k < n; k++) req_txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      v = $urandom_range(0, 5);
      if (v < 4) begin
        for (k = 0; k < VERB_LEN[v]; k++) req_txt.push_back(VERB_TXT[v][k]);
      end else if (v == 4) begin
        m = $urandom_range(0, 3);
        n = $urandom_range(0, VERB_LEN[m] - 1);
        for (k = 0; k < n; k++) req_txt.push_back(VERB_TXT[m][k]);
        req_txt.push_back(pick_char(1'b1, 1'b0, 1'b0));
      end else begin
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) req_txt.push_back(pick_char(1'b0, 1'b0, 1'b0));
      end
      req_txt.push_back(($urandom_range(0, 9) != 0) ? CH_SPACE : pick_char(1'b0, 1'b0, 1'b0));
      n = $urandom_range(0, 5);
      for (k = 0; k < n; k++) req_txt.push_back(pick_char(1'b1, 1'b0, 1'b0));
      case ($urandom_range(0, 7))
        0: req_txt.push_back(CH_TAB);
        1: req_txt.push_back(CH_LF);
        2: req_txt.push_back(CH_VT);
        3: req_txt.push_back(CH_FF);
        4: req_txt.push_back(CH_CR);
        default: req_txt.push_back(CH_SPACE);
      endcase
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) req_txt.push_back(pick_char(1'b0, 1'b0, 1'b1));
      req_txt.push_back(CH_LF);
      n = ($urandom_range(0, 14) == 0) ? HRSP_MAX_HEADERS + 1 : $urandom_range(0, 2);
      for (h = 0; h < n; h++) begin
        req_txt.push_back(pick_char(1'b0, 1'b1, 1'b1));
        m = $urandom_range(0, 2);
        for (k = 0; k < m; k++) req_txt.push_back(pick_char(1'b0, 1'b1, 1'b0));
        req_txt.push_back(CH_COLON);
        m = $urandom_range(0, 2);
        for (k = 0; k < m; k++) req_txt.push_back(CH_SPACE);
        m = $urandom_range(0, 3);
        for (k = 0; k < m; k++) req_txt.push_back(pick_char(1'b0, 1'b0, 1'b1));
        req_txt.push_back(CH_LF);
      end
      req_txt.push_back(($urandom_range(0, 3) == 0) ? CH_NUL : CH_LF);
      n = $urandom_range(0, 2);
      for (k = 0; k < n; k++) req_txt.push_back(CH_LF);
      n = $urandom_range(0, 3);
      for (k = 0; k < n; k++) req_txt.push_back(pick_char(1'b0, 1'b0, 1'b0));
    end
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, req_txt.size());
      while (req_txt.size() > cut) void'(req_txt.pop_back());
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    bit calm;
    int k;
    calm = (n_accepted >= calm_lo) && (n_accepted < calm_hi);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_words++;
        if (span_q.size() == 0) begin
          note_diff("word with nothing pending", out_tdata, '0);
        end else begin
          want = span_q.pop_front();
          if (out_tuser != want.kind) note_diff("span_kind", 40'(out_tuser), 40'(want.kind));
          if (out_tdata[2:0] != want.code) begin
            note_diff("method_code", 40'(out_tdata[2:0]), 40'(want.code));
          end
          if (out_tdata[18:3] != want.start) begin
            note_diff("span_start", 40'(out_tdata[18:3]), 40'(want.start));
          end
          if (out_tdata[34:19] != want.length) begin
            note_diff("span_length", 40'(out_tdata[34:19]), 40'(want.length));
          end
          if (out_tdata[38:35] != want.slot) begin
            note_diff("header_slot", 40'(out_tdata[38:35]), 40'(want.slot));
          end
          if (out_tdata[39] != 1'b0) note_diff("pad bit", 40'(out_tdata[39]), '0);
          if (out_tlast != want.last) note_diff("last_result", 40'(out_tlast), 40'(want.last));
        end
      end
      if (in_tvalid && in_tready) begin
        parse_byte(on_bus.data, on_bus.fin);
        if (on_bus.known) begin
          for (k = 0; k < row_known[on_bus.row]; k++) span_q.push_back(row_word[on_bus.row][k]);
        end else begin
          for (k = 0; k < span_buf.size(); k++) span_q.push_back(span_buf[k]);
        end
        n_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (stim_q.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
          on_bus = stim_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= on_bus.data;
          in_tlast <= on_bus.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  initial begin
    int r, k, rand_from, spins;
    reset_parser();

    // Rows with a known answer are single requests whose words follow directly from the
    // rules; the remaining rows are checked against the predictor.
    row_txt = '{
      "x", "\377", " ", "G", "\n", "DELETE", "GET",
      "GET /a HTTP/1.1\nHost: h\n\nbody",
      "POST /p\nK:   v\nX:\n\n\n\nzz",
      "PUT\t/x\nk:v\n",
      "DELET /q\n",
      "PUTX /u\n",
      "GEX /\nabc",
      "GET /u\tz\nk: ",
      "GET /u\nk:v",
      "GET /long",
      "GET /\n?body",
      "GET \v\r\n\n",
      "POST \f\nA:b\n",
      "GE"
    };
    row_nul = '{0, -1, -1, -1, -1, -1, -1, -1, -1, -1,
                -1, -1, -1, -1, -1, -1, 6, -1, -1, -1};
    row_known = '{2, 2, 3, 2, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    row_word[0] = '{span_word(KIND_METHOD, MC_NONE, 0, 0, 0, 1'b0),
                    span_word(KIND_BODY, MC_NONE, 1, 0, 0, 1'b1), '0};
    row_word[1] = '{span_word(KIND_METHOD, MC_NONE, 0, 0, 0, 1'b0),
                    span_word(KIND_BODY, MC_NONE, 1, 0, 0, 1'b1), '0};
    row_word[2] = '{span_word(KIND_METHOD, MC_NONE, 0, 0, 0, 1'b0),
                    span_word(KIND_URL, MC_NONE, 1, 0, 0, 1'b0),
                    span_word(KIND_BODY, MC_NONE, 1, 0, 0, 1'b1)};
    row_word[3] = '{span_word(KIND_METHOD, MC_NONE, 0, 0, 0, 1'b0),
                    span_word(KIND_BODY, MC_NONE, 1, 0, 0, 1'b1), '0};
    row_word[4] = '{span_word(KIND_METHOD, MC_NONE, 0, 0, 0, 1'b0),
                    span_word(KIND_BODY, MC_NONE, 1, 0, 0, 1'b1), '0};
    row_word[5] = '{span_word(KIND_METHOD, MC_DELETE, 0, 6, 0, 1'b0),
                    span_word(KIND_BODY, MC_NONE, 6, 0, 0, 1'b1), '0};
    row_word[6] = '{span_word(KIND_METHOD, MC_GET, 0, 3, 0, 1'b0),
                    span_word(KIND_BODY, MC_NONE, 3, 0, 0, 1'b1), '0};

    for (r = 0; r < N_ROWS; r++) begin
      req_txt.delete();
      push_text(row_txt[r]);
      if (row_nul[r] >= 0) req_txt[row_nul[r]] = CH_NUL;
      add_request((row_known[r] > 0) ? r : -1);
    end

    req_txt.delete();
    push_text("GET /\n");
    for (k = 0; k <= HRSP_MAX_HEADERS; k++) push_text("k:v\n");
    push_text("\nend");
    add_request(-1);
    n_directed = n_requests;

    rand_from = stim_q.size();
    calm_lo = 60;
    calm_hi = calm_lo + 120;
    while (stim_q.size() - rand_from < RANDOM_BYTES) begin
      build_random_request();
      add_request(-1);
    end
    n_stim = stim_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_stim) @(posedge clk);
    spins = 0;
    while (span_q.size() != 0 && spins < DRAIN_LIMIT) begin
      @(posedge clk);
      spins++;
    end
    repeat (16) @(posedge clk);
    if (span_q.size() != 0) note_diff("words never produced", 40'(span_q.size()), '0);

    $display("Sent %0d requests (%0d directed), %0d bytes.",
             n_requests, n_directed, n_accepted);
    $display("Compared %0d span words; %0d field errors.", n_words, n_err);
    if (n_err == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
